>>> design/ray_reflect_refract_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ray reflect/refract unit
// ---------------------------------------------------------------------------
`ifndef RAY_REFLECT_REFRACT_UNIT_DEFINES_SVH
`define RAY_REFLECT_REFRACT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RRR_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define RRR_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define RRR_ASSERT_IMPL(lbl, clk, rst, a, c)
`define RRR_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> design/rrr_pkg.sv
// ---------------------------------------------------------------------------
// rrr_pkg
// Shared constants and types of the ray reflect/refract unit.
// ---------------------------------------------------------------------------
package rrr_pkg;
   localparam int FRAC_BITS_DEF  = 24;
   localparam int COMP_WIDTH_DEF = 32;
   localparam int IN_WIDTH       = 32;
   localparam int ETA_WIDTH      = 28;

   typedef enum logic {
      OP_REFLECT = 1'b0,
      OP_REFRACT = 1'b1
   } op_type;
endpackage

>>> design/rrr_if.sv
// ---------------------------------------------------------------------------
// rrr_req_if / rrr_rsp_if
// Valid/ready channels of the ray reflect/refract unit.
// ---------------------------------------------------------------------------
interface rrr_req_if;
   import rrr_pkg::*;
   logic                        valid;
   logic                        ready;
   op_type                      operation;
   logic signed [IN_WIDTH-1:0]  dir_x;
   logic signed [IN_WIDTH-1:0]  dir_y;
   logic signed [IN_WIDTH-1:0]  dir_z;
   logic signed [IN_WIDTH-1:0]  normal_x;
   logic signed [IN_WIDTH-1:0]  normal_y;
   logic signed [IN_WIDTH-1:0]  normal_z;
   logic [ETA_WIDTH-1:0]        eta_ratio;
   modport source (output valid, operation, dir_x, dir_y, dir_z, normal_x, normal_y,
                   normal_z, eta_ratio, input ready);
   modport sink (input valid, operation, dir_x, dir_y, dir_z, normal_x, normal_y,
                 normal_z, eta_ratio, output ready);
endinterface

interface rrr_rsp_if;
   import rrr_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [IN_WIDTH-1:0]  out_x;
   logic signed [IN_WIDTH-1:0]  out_y;
   logic signed [IN_WIDTH-1:0]  out_z;
   logic                        saturated;
   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

>>> design/ray_reflect_refract_unit.sv
// ---------------------------------------------------------------------------
// ray_reflect_refract_unit
// Mirror reflection and Snell refraction of a ray direction, fixed point.
// ---------------------------------------------------------------------------
// channel  dir  fields
// req      in   operation, dir_x/y/z, normal_x/y/z, eta_ratio
// rsp      out  out_x/y/z, saturated
// One transfer per cycle while rsp is not stalled; the path is 11 register stages
// plus the root pipeline, one stage per root bit (RW of them).
// Synchronous reset clears the valid bits only.
// A stalled rsp freezes the whole pipeline; ready is high whenever the last
// stage is empty or being taken.
`include "ray_reflect_refract_unit_defines.svh"
module ray_reflect_refract_unit
   import rrr_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   rrr_req_if.sink   req,
   rrr_rsp_if.source rsp
);
   localparam int CW = COMP_WIDTH;
   localparam int PW = (2*CW + 4 > CW + ETA_WIDTH + 2) ? 2*CW + 4 : CW + ETA_WIDTH + 2;
   localparam int RW = (CW + 3 > FRAC_BITS + 1) ? CW + 3 : FRAC_BITS + 1;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE  =
      (FRAC_BITS >= CW-1) ? CMAX : CW'(64'd1 << FRAC_BITS);

   typedef logic signed [CW-1:0] comp_type;
   typedef logic signed [PW-1:0] wide_type;

   function automatic comp_type sat(input wide_type v, output logic f);
      f = 1'b0;
      if (v > wide_type'(CMAX)) begin
         f = 1'b1;
         return CMAX;
      end
      if (v < wide_type'(CMIN)) begin
         f = 1'b1;
         return CMIN;
      end
      return comp_type'(v);
   endfunction

   function automatic wide_type mul(input comp_type a, input comp_type b);
      return wide_type'(a) * wide_type'(b);
   endfunction

   logic en;
   logic vld_ff [8];

   // stage 1: clamp inputs
   op_type   op1_ff;
   comp_type d1_ff [3], n1_ff [3];
   logic [ETA_WIDTH-1:0] eta1_ff;
   logic     f1_ff;
   // stage 2: products of dot
   op_type   op2_ff;
   comp_type d2_ff [3], n2_ff [3];
   logic [ETA_WIDTH-1:0] eta2_ff;
   wide_type p2_ff [3];
   logic     f2_ff;
   // stage 3: dot scaled/saturated, k or c
   op_type   op3_ff;
   comp_type d3_ff [3], n3_ff [3], k3_ff;
   logic [ETA_WIDTH-1:0] eta3_ff;
   logic     f3_ff;
   // stage 4: products k*n
   op_type   op4_ff;
   comp_type d4_ff [3], n4_ff [3];
   wide_type m4_ff [3];
   logic [ETA_WIDTH-1:0] eta4_ff;
   logic     f4_ff;
   // stage 5: reflect result or s
   op_type   op5_ff;
   comp_type n5_ff [3], v5_ff [3];
   logic [ETA_WIDTH-1:0] eta5_ff;
   logic     f5_ff;
   // stage 6: eta*s
   op_type   op6_ff;
   comp_type n6_ff [3], v6_ff [3];
   wide_type m6_ff [3];
   logic     f6_ff;
   // stage 7: perp
   op_type   op7_ff;
   comp_type n7_ff [3], v7_ff [3];
   logic     f7_ff;
   // stage 8: perp squares
   op_type   op8_ff;
   comp_type n8_ff [3], v8_ff [3];
   wide_type q8_ff [3];
   logic     f8_ff;
   // stage 9: radicand
   logic [2*RW-1:0] rad9_ff;

   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // clamping at entry
   comp_type d0 [3], n0 [3];
   logic     f0;
   always_comb begin
      logic fa, fb;
      logic signed [IN_WIDTH-1:0] di [3], ni [3];
      di = '{req.dir_x, req.dir_y, req.dir_z};
      ni = '{req.normal_x, req.normal_y, req.normal_z};
      f0 = 1'b0;
      for (int i = 0; i < 3; i++) begin
         d0[i] = sat(wide_type'(di[i]), fa);
         n0[i] = sat(wide_type'(ni[i]), fb);
         f0 = f0 | fa | fb;
      end
   end

   // stage 3 comb
   comp_type k3_in;
   logic     f3_in;
   always_comb begin
      wide_type s, t;
      comp_type k, c;
      logic fa, fb, fc;
      c = '0;
      s = (p2_ff[0] + p2_ff[1] + p2_ff[2]) >>> FRAC_BITS;
      k = sat(s, fa);
      if (op2_ff == OP_REFLECT) begin
         k3_in = sat(wide_type'(k) * 2, fb);
         fc = 1'b0;
      end else begin
         c = sat(-wide_type'(k), fb);
         fc = 1'b0;
         k3_in = (c > ONE) ? ONE : c;
      end
      f3_in = f2_ff | fa | fb | fc;
   end

   // stage 5 comb
   comp_type v5_in [3];
   logic     f5_in;
   always_comb begin
      logic fa, fb;
      comp_type m;
      f5_in = f4_ff;
      for (int i = 0; i < 3; i++) begin
         m = sat(m4_ff[i] >>> FRAC_BITS, fa);
         if (op4_ff == OP_REFLECT) begin
            v5_in[i] = sat(wide_type'(d4_ff[i]) - wide_type'(m), fb);
         end else begin
            v5_in[i] = sat(wide_type'(d4_ff[i]) + wide_type'(m), fb);
         end
         f5_in = f5_in | fa | fb;
      end
   end

   // stage 7 comb
   comp_type v7_in [3];
   logic     f7_in;
   always_comb begin
      logic fa;
      fa = 1'b0;
      f7_in = f6_ff;
      for (int i = 0; i < 3; i++) begin
         if (op6_ff == OP_REFRACT) begin
            v7_in[i] = sat(m6_ff[i] >>> FRAC_BITS, fa);
            f7_in = f7_in | fa;
         end else begin
            v7_in[i] = v6_ff[i];
         end
      end
   end

   // stage 9 comb
   logic [2*RW-1:0] rad9_in;
   always_comb begin
      logic signed [2*RW:0] w;
      w = (2*RW+1)'(1) << (2*FRAC_BITS);
      w = w - (2*RW+1)'(q8_ff[0]) - (2*RW+1)'(q8_ff[1]) - (2*RW+1)'(q8_ff[2]);
      if (w < 0) begin
         w = -w;
      end
      rad9_in = w[2*RW-1:0];
   end

   localparam int SW = 1 + 1 + 6*CW;
   logic [SW-1:0] side9_in, side_out;
   logic          rt_valid;
   logic [RW-1:0] root;
   assign side9_in = {op8_ff, f8_ff, n8_ff[0], n8_ff[1], n8_ff[2],
                      v8_ff[0], v8_ff[1], v8_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < 8; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      if (en) begin
         op1_ff <= req.operation;
         d1_ff <= d0; n1_ff <= n0; eta1_ff <= req.eta_ratio; f1_ff <= f0;

         op2_ff <= op1_ff; d2_ff <= d1_ff; n2_ff <= n1_ff; eta2_ff <= eta1_ff;
         f2_ff <= f1_ff;
         for (int i = 0; i < 3; i++) begin
            p2_ff[i] <= mul(d1_ff[i], n1_ff[i]);
         end

         op3_ff <= op2_ff; d3_ff <= d2_ff; n3_ff <= n2_ff; eta3_ff <= eta2_ff;
         k3_ff <= k3_in; f3_ff <= f3_in;

         op4_ff <= op3_ff; d4_ff <= d3_ff; n4_ff <= n3_ff; eta4_ff <= eta3_ff;
         f4_ff <= f3_ff;
         for (int i = 0; i < 3; i++) begin
            m4_ff[i] <= mul(k3_ff, n3_ff[i]);
         end

         op5_ff <= op4_ff; n5_ff <= n4_ff; v5_ff <= v5_in; eta5_ff <= eta4_ff;
         f5_ff <= f5_in;

         op6_ff <= op5_ff; n6_ff <= n5_ff; v6_ff <= v5_ff; f6_ff <= f5_ff;
         for (int i = 0; i < 3; i++) begin
            m6_ff[i] <= wide_type'($signed({1'b0, eta5_ff})) * wide_type'(v5_ff[i]);
         end

         op7_ff <= op6_ff; n7_ff <= n6_ff; v7_ff <= v7_in; f7_ff <= f7_in;

         op8_ff <= op7_ff; n8_ff <= n7_ff; v8_ff <= v7_ff; f8_ff <= f7_ff;
         for (int i = 0; i < 3; i++) begin
            q8_ff[i] <= mul(v7_ff[i], v7_ff[i]);
         end
         rad9_ff <= rad9_in;
      end
   end

   logic          v9_ff;
   logic [SW-1:0] side9_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= vld_ff[7];
      end
      if (en) begin
         side9_ff <= side9_in;
      end
   end

   rrr_isqrt #(.RW(RW), .SW(SW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_rad    (rad9_ff),
      .in_side   (side9_ff),
      .out_valid (rt_valid),
      .out_root  (root),
      .out_side  (side_out)
   );

   // post-root: saturate r, products, final sum
   op_type   opa;
   logic     fa0;
   comp_type na [3], va [3];
   assign opa = op_type'(side_out[SW-1]);
   assign {fa0, na[0], na[1], na[2], va[0], va[1], va[2]} = side_out[SW-2:0];

   comp_type r_a;
   logic     fr;
   always_comb begin
      if ({{(PW-RW){1'b0}}, root} > PW'(CMAX)) begin
         r_a = CMAX;
         fr  = 1'b1;
      end else begin
         r_a = comp_type'(root);
         fr  = 1'b0;
      end
   end

   logic     vb_ff;
   op_type   opb_ff;
   logic     fb_ff;
   comp_type vb_ff3 [3];
   wide_type mb_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= rt_valid;
      end
      if (en) begin
         opb_ff <= opa;
         fb_ff  <= fa0 | ((opa == OP_REFRACT) & fr);
         vb_ff3 <= va;
         for (int i = 0; i < 3; i++) begin
            mb_ff[i] <= -wide_type'(r_a) * wide_type'(na[i]);
         end
      end
   end

   comp_type res [3];
   logic     fres;
   always_comb begin
      logic fa, fb;
      comp_type m;
      fa = 1'b0;
      fb = 1'b0;
      m = '0;
      fres = fb_ff;
      for (int i = 0; i < 3; i++) begin
         if (opb_ff == OP_REFRACT) begin
            m = sat(mb_ff[i] >>> FRAC_BITS, fa);
            res[i] = sat(wide_type'(vb_ff3[i]) + wide_type'(m), fb);
            fres = fres | fa | fb;
         end else begin
            res[i] = vb_ff3[i];
         end
      end
   end

   logic     ov_ff;
   comp_type o_ff [3];
   logic     of_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= vb_ff;
      end
      if (en) begin
         o_ff  <= res;
         of_ff <= fres;
      end
   end

   assign rsp.valid     = ov_ff;
   assign rsp.out_x     = IN_WIDTH'(o_ff[0]);
   assign rsp.out_y     = IN_WIDTH'(o_ff[1]);
   assign rsp.out_z     = IN_WIDTH'(o_ff[2]);
   assign rsp.saturated = of_ff;

   `RRR_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `RRR_ASSERT_IMPL(a_ready_free, clock, reset, !rsp.valid, req.ready)
   `RRR_ASSERT_NEXT(a_root_adv, clock, reset, en && rt_valid, vb_ff)
endmodule

>>> design/rrr_isqrt.sv
// ---------------------------------------------------------------------------
// rrr_isqrt
// Pipelined integer square root, restoring shift-and-subtract, one result
// bit per stage, with a sideband word carried alongside.
// ---------------------------------------------------------------------------
module rrr_isqrt #(
   parameter int RW = 49,
   parameter int SW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2*RW-1:0]      in_rad,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [RW-1:0]        out_root,
   output logic [SW-1:0]        out_side
);
   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int B = RW - 1 - s;
      logic            vld_ff;
      logic [RW-1:0]   root_ff;
      logic [SW-1:0]   side_ff;
      logic            stage_vld;
      logic [2*RW-1:0] stage_rem;
      logic [RW-1:0]   stage_root;
      logic [SW-1:0]   stage_side;
      logic [2*RW-1:0] trial;
      logic            take;

      if (s == 0) begin : g_head
         assign stage_vld  = in_valid;
         assign stage_rem  = in_rad;
         assign stage_root = '0;
         assign stage_side = in_side;
      end else begin : g_body
         assign stage_vld  = g_stage[s-1].vld_ff;
         assign stage_rem  = g_stage[s-1].g_rem.rem_ff;
         assign stage_root = g_stage[s-1].root_ff;
         assign stage_side = g_stage[s-1].side_ff;
      end

      // (r + 2^B)^2 - r^2 = (r << (B+1)) | (1 << 2B), r holds only bits above B
      always_comb begin
         trial = ((2*RW)'(stage_root) << (B + 1)) | ((2*RW)'(1) << (2 * B));
         take  = (stage_rem >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= stage_vld;
         end
         if (en) begin
            side_ff <= stage_side;
            root_ff <= take ? (stage_root | (RW'(1) << B)) : stage_root;
         end
      end

      if (s < RW - 1) begin : g_rem
         logic [2*RW-1:0] rem_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= take ? (stage_rem - trial) : stage_rem;
            end
         end
      end
   end

   assign out_valid = g_stage[RW-1].vld_ff;
   assign out_root  = g_stage[RW-1].root_ff;
   assign out_side  = g_stage[RW-1].side_ff;
endmodule

>>> dv/ray_reflect_refract_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_reflect_refract_unit_checker
// Watches the req and rsp channels, computes the expected reflected or
// refracted direction of each req transfer and compares each rsp transfer
// with the oldest expected one. Channels are sampled at the falling edge.
// ---------------------------------------------------------------------------
module ray_reflect_refract_unit_checker
   import rrr_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   rrr_req_if    req,
   rrr_rsp_if    rsp,
   output int    mismatches,
   output int    outstanding,
   output int    checked
);
   localparam int FRAC = FRAC_BITS_DEF;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               sat;
   } dir_result_type;

   localparam wide_type CMAX = 128'sd2147483647;
   localparam wide_type CMIN = -128'sd2147483648;

   dir_result_type expected_dirs[$];

   function automatic longint clip(input wide_type v, inout bit sat);
      if (v > CMAX) begin
         sat = 1'b1;
         return longint'(CMAX);
      end
      if (v < CMIN) begin
         sat = 1'b1;
         return longint'(CMIN);
      end
      return longint'(v);
   endfunction

   function automatic longint fmul(input longint a, input longint b, inout bit sat);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      return clip(p >>> FRAC, sat);
   endfunction

   function automatic longint fdot(input longint a[3], input longint b[3], inout bit sat);
      wide_type s;
      s = wide_type'(a[0]) * wide_type'(b[0]) + wide_type'(a[1]) * wide_type'(b[1])
          + wide_type'(a[2]) * wide_type'(b[2]);
      return clip(s >>> FRAC, sat);
   endfunction

   function automatic longint floor_sqrt(input logic [127:0] w);
      logic [127:0] r;
      logic [127:0] cand;
      r = '0;
      for (int b = 48; b >= 0; b--) begin
         cand = r | (128'd1 << b);
         if (cand * cand <= w) r = cand;
      end
      return longint'(r);
   endfunction

   function automatic dir_result_type scatter(input op_type op, input longint d[3],
                                              input longint n[3], input longint eta);
      dir_result_type res;
      bit             sat;
      longint         k, t, c, r, s;
      longint         perp[3];
      longint         o[3];
      wide_type       len2, w;
      sat = 1'b0;
      if (op == OP_REFLECT) begin
         k = fdot(d, n, sat);
         t = clip(wide_type'(2) * wide_type'(k), sat);
         for (int i = 0; i < 3; i++)
            o[i] = clip(wide_type'(d[i]) - wide_type'(fmul(t, n[i], sat)), sat);
      end else begin
         c = clip(-wide_type'(fdot(d, n, sat)), sat);
         if (c > (64'sd1 << FRAC)) c = 64'sd1 << FRAC;
         len2 = '0;
         for (int i = 0; i < 3; i++) begin
            s = clip(wide_type'(d[i]) + wide_type'(fmul(c, n[i], sat)), sat);
            perp[i] = fmul(eta, s, sat);
            len2 += wide_type'(perp[i]) * wide_type'(perp[i]);
         end
         w = (wide_type'(1) << (2 * FRAC)) - len2;
         if (w < 0) w = -w;
         r = floor_sqrt(w);
         if (wide_type'(r) > CMAX) begin
            r = longint'(CMAX);
            sat = 1'b1;
         end
         for (int i = 0; i < 3; i++)
            o[i] = clip(wide_type'(perp[i]) + wide_type'(fmul(-r, n[i], sat)), sat);
      end
      res.x = o[0][31:0];
      res.y = o[1][31:0];
      res.z = o[2][31:0];
      res.sat = sat;
      return res;
   endfunction

   initial begin
      mismatches = 0;
      outstanding = 0;
      checked = 0;
   end

   always @(negedge clock) begin
      longint         d[3];
      longint         n[3];
      dir_result_type exp_dir;
      if (!reset && req.valid && req.ready) begin
         d[0] = req.dir_x;
         d[1] = req.dir_y;
         d[2] = req.dir_z;
         n[0] = req.normal_x;
         n[1] = req.normal_y;
         n[2] = req.normal_z;
         expected_dirs.push_back(scatter(req.operation, d, n, longint'(req.eta_ratio)));
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: rsp transfer with nothing expected", $realtime);
         end else begin
            exp_dir = expected_dirs.pop_front();
            checked++;
            if (rsp.out_x !== exp_dir.x || rsp.out_y !== exp_dir.y ||
                rsp.out_z !== exp_dir.z || rsp.saturated !== exp_dir.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch exp %h %h %h sat %b got %h %h %h sat %b",
                           $realtime, exp_dir.x, exp_dir.y, exp_dir.z, exp_dir.sat,
                           rsp.out_x, rsp.out_y, rsp.out_z, rsp.saturated);
            end
         end
      end
      outstanding = expected_dirs.size();
   end
endmodule

>>> dv/ray_reflect_refract_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_reflect_refract_unit_tb
// Drives directed and random reflect/refract requests into the unit with
// random gaps and back-pressure, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module ray_reflect_refract_unit_tb;
   import rrr_pkg::*;

   localparam int RANDOM_ITEMS = 1930;
   localparam int CALM_ITEMS   = 200;
   localparam int IDLE_LIMIT   = 5000;
   localparam int ONE          = 1 << 24;

   logic clock;
   logic reset;
   bit   calm;
   bit   stim_done;
   int   mismatches, outstanding, checked;
   int   idle_cycles;
   int   reflect_sent, refract_sent;

   rrr_req_if req_if ();
   rrr_rsp_if rsp_if ();

   ray_reflect_refract_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   ray_reflect_refract_unit_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_ray(input op_type op, input int dx, input int dy, input int dz,
                           input int nx, input int ny, input int nz, input int eta);
      bit taken;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.dir_x     <= dx;
      req_if.dir_y     <= dy;
      req_if.dir_z     <= dz;
      req_if.normal_x  <= nx;
      req_if.normal_y  <= ny;
      req_if.normal_z  <= nz;
      req_if.eta_ratio <= eta[ETA_WIDTH-1:0];
      if (op == OP_REFLECT) reflect_sent++;
      else refract_sent++;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic int unit_comp();
      return int'($urandom_range(0, 2 * ONE)) - ONE;
   endfunction

   initial begin
      int     eta;
      op_type op;
      reset = 1'b1;
      calm = 1'b0;
      stim_done = 1'b0;
      req_if.valid <= 1'b0;
      req_if.operation <= OP_REFLECT;
      req_if.dir_x <= '0;
      req_if.dir_y <= '0;
      req_if.dir_z <= '0;
      req_if.normal_x <= '0;
      req_if.normal_y <= '0;
      req_if.normal_z <= '0;
      req_if.eta_ratio <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_ray(OP_REFLECT, 0, 0, -ONE, 0, 0, ONE, 0);
      send_ray(OP_REFLECT, ONE, -ONE, 0, 0, ONE, 0, 32'h0FFF_FFFF);
      send_ray(OP_REFLECT, 0, 0, 0, 0, 0, 0, 0);
      send_ray(OP_REFLECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_ray(OP_REFLECT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, ONE);
      send_ray(OP_REFLECT, 32'hFFFF_FFFF, 1, 32'h8000_0000, 1, 32'hFFFF_FFFF, 0, 0);
      send_ray(OP_REFRACT, 0, 0, -ONE, 0, 0, ONE, ONE);
      send_ray(OP_REFRACT, ONE / 2, 0, -ONE / 2, 0, 0, ONE, ONE);
      send_ray(OP_REFRACT, ONE / 2, 0, -ONE / 2, 0, 0, ONE, 3 * ONE / 2);
      send_ray(OP_REFRACT, ONE, 0, -ONE / 16, 0, 0, ONE, 2 * ONE);
      send_ray(OP_REFRACT, ONE / 2, ONE / 4, -ONE / 2, 0, 0, ONE, 0);
      send_ray(OP_REFRACT, ONE / 2, ONE / 4, -ONE / 2, 0, 0, ONE, 32'h0FFF_FFFF);
      send_ray(OP_REFRACT, 0, 0, ONE, 0, 0, ONE, ONE);
      send_ray(OP_REFRACT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE);
      send_ray(OP_REFRACT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0FFF_FFFF);
      send_ray(OP_REFRACT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0FFF_FFFF);
      send_ray(OP_REFRACT, 0, 0, 0, 0, 0, 0, 32'h0FFF_FFFF);
      send_ray(OP_REFRACT, 4 * ONE, -3 * ONE, 0, ONE, 0, 0, 5 * ONE);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         op = op_type'($urandom_range(0, 1));
         if ($urandom_range(0, 9) < 6) begin
            eta = $urandom_range(0, 2 * ONE);
            send_ray(op, unit_comp(), unit_comp(), unit_comp(),
                     unit_comp(), unit_comp(), unit_comp(), eta);
         end else begin
            eta = $urandom();
            send_ray(op, $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), eta);
         end
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL ray_reflect_refract_unit");
         $finish;
      end
   end

   initial begin
      idle_cycles = 0;
      reflect_sent = 0;
      refract_sent = 0;
      wait (stim_done);
      repeat (2) @(negedge clock);
      wait (outstanding == 0);
      repeat (80) @(posedge clock);
      $display("Sent %0d reflect and %0d refract rays, %0d results checked",
               reflect_sent, refract_sent, checked);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS ray_reflect_refract_unit");
      else
         $display("FAIL ray_reflect_refract_unit");
      $finish;
   end
endmodule
